### hw/rtl/cfws_pkg.sv
// ============================================================================
// cfws_pkg - circular FIFO with search, shared definitions
// Field widths, codes, defaults and the command/status structs that pass
// between the controller and the datapath.
// ============================================================================
package cfws_pkg;

    localparam int OP_W   = 2;
    localparam int VAL_W  = 32;
    localparam int ST_W   = 2;
    localparam int SLOT_W = 7;
    localparam int OCC_W  = 8;
    localparam int CAP_W  = 8;

    localparam int DEPTH_DEFAULT      = 128;
    localparam int DATA_WIDTH_DEFAULT = 32;
    localparam int DEFAULT_CAPACITY   = 100;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_SEARCH = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } res_code_t;

    // controller -> datapath
    typedef struct packed {
        logic accept;       // capture the input transaction
        logic exec;         // carry out the operation
        logic front_load;   // take the new head entry from the RAM
        logic scan;         // compare one entry, advance on a miss
        logic result_load;  // load the result register
    } ctl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        op_t  op;
        logic empty;
        logic match;
        logic last;
    } dp_stat_t;

endpackage

### hw/rtl/cfws_in_if.sv
// ============================================================================
// cfws_in_if - input channel
// Valid/ready channel carrying one operation and its operand.
// ============================================================================
interface cfws_in_if;
    import cfws_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [OP_W-1:0]         operation;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, output operation, output value, input ready);
    modport sink   (input valid, input operation, input value, output ready);
endinterface

### hw/rtl/cfws_out_if.sv
// ============================================================================
// cfws_out_if - result channel
// Valid/ready channel carrying the outcome of one operation and queue status.
// ============================================================================
interface cfws_out_if;
    import cfws_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [ST_W-1:0]         status;
    logic                    found;
    logic [SLOT_W-1:0]       found_slot;
    logic signed [VAL_W-1:0] front_value;
    logic signed [VAL_W-1:0] back_value;
    logic [OCC_W-1:0]        occupancy;
    logic                    is_empty;
    logic                    is_full;

    modport source (
        output valid, output status, output found, output found_slot,
        output front_value, output back_value, output occupancy,
        output is_empty, output is_full, input ready
    );
    modport sink (
        input valid, input status, input found, input found_slot,
        input front_value, input back_value, input occupancy,
        input is_empty, input is_full, output ready
    );
endinterface

### hw/rtl/circular_fifo_with_search_core.sv
// ============================================================================
// circular_fifo_with_search_core - circular FIFO with linear search
// Queue of run-time capacity taking push, pop and search transactions and
// returning one result per transaction with the queue status after it.
// ============================================================================
//
//  channel   dir  handshake      payload
//  -------   ---  -------------  ---------------------------------------------
//  item      in   valid/ready    operation, value
//  result    out  valid/ready    status, found, found_slot, front_value,
//                                back_value, occupancy, is_empty, is_full
//  cfg       in   cfg_we         cfg_data (capacity)
//
//  Steps: push, error cases and the unused code go through accept, execute
//  and result load; pop adds one extra RAM read for the new head before the
//  load; search adds one scan step per entry examined, as the RAM has one read port.
//  One transaction is in flight at a time; the next is accepted once the
//  previous has loaded the result register, even while that result waits.
//  Reset: asynchronous, active low; queue empty, capacity 100 (or DEPTH).
//  Stalls: a held result blocks only the final load of the next transaction.
//
module circular_fifo_with_search_core #(
    parameter int DEPTH      = cfws_pkg::DEPTH_DEFAULT,
    parameter int DATA_WIDTH = cfws_pkg::DATA_WIDTH_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [cfws_pkg::CAP_W-1:0] cfg_data,
    cfws_in_if.sink                    item,
    cfws_out_if.source                 result
);
    import cfws_pkg::*;

    ctl_cmd_t cmd;    // sequencing commands into the datapath
    dp_stat_t stat;   // operation and compare outcome back to the controller

    // Controller: walks each transaction through its steps and owns the
    // handshakes of both channels.
    cfws_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item.valid),
        .in_ready  (item.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Datapath: pointers, slot RAM, search compare and the result register.
    cfws_dp #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_data        (cfg_data),
        .cmd             (cmd),
        .stat            (stat),
        .in_operation    (item.operation),
        .in_value        (item.value),
        .res_status      (result.status),
        .res_found       (result.found),
        .res_found_slot  (result.found_slot),
        .res_front_value (result.front_value),
        .res_back_value  (result.back_value),
        .res_occupancy   (result.occupancy),
        .res_is_empty    (result.is_empty),
        .res_is_full     (result.is_full)
    );
endmodule

### hw/rtl/cfws_ram.sv
// ============================================================================
// cfws_ram - generic single-port-write RAM
// One write port, one read port, registered read data.
// ============================================================================
module cfws_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

### hw/rtl/cfws_ctrl.sv
// ============================================================================
// cfws_ctrl - sequencing controller
// Steps each transaction through execute, head refresh or scan, and result.
// ============================================================================
module cfws_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  cfws_pkg::dp_stat_t stat,
    output cfws_pkg::ctl_cmd_t cmd
);
    import cfws_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_FRONT,
        S_SCAN,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        cmd             = '0;
        state_next      = state_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                case (stat.op)
                    OP_POP:    state_next = stat.empty ? S_FINISH : S_FRONT;
                    OP_SEARCH: state_next = stat.empty ? S_FINISH : S_SCAN;
                    default:   state_next = S_FINISH;
                endcase
            end
            S_FRONT:
            begin
                cmd.front_load = 1'b1;
                state_next     = S_FINISH;
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.match || stat.last)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (slot_free)
                begin
                    cmd.result_load = 1'b1;
                    out_valid_next  = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    a_load_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.result_load |-> (!out_valid_reg || out_ready))
        else $error("result loaded over an untaken result");
    a_scan_follows_exec: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(cmd.scan) |-> $past(cmd.exec))
        else $error("scan entered without execute");
    a_accept_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |=> cmd.exec)
        else $error("accepted transaction not executed");
`endif
endmodule

### hw/rtl/cfws_dp.sv
// ============================================================================
// cfws_dp - queue datapath
// Pointers, occupancy, capacity, slot RAM, search compare and result register.
// ============================================================================
module cfws_dp #(
    parameter int DEPTH      = cfws_pkg::DEPTH_DEFAULT,
    parameter int DATA_WIDTH = cfws_pkg::DATA_WIDTH_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [cfws_pkg::CAP_W-1:0]        cfg_data,
    input  cfws_pkg::ctl_cmd_t                cmd,
    output cfws_pkg::dp_stat_t                stat,
    input  logic [cfws_pkg::OP_W-1:0]         in_operation,
    input  logic signed [cfws_pkg::VAL_W-1:0] in_value,
    output logic [cfws_pkg::ST_W-1:0]         res_status,
    output logic                              res_found,
    output logic [cfws_pkg::SLOT_W-1:0]       res_found_slot,
    output logic signed [cfws_pkg::VAL_W-1:0] res_front_value,
    output logic signed [cfws_pkg::VAL_W-1:0] res_back_value,
    output logic [cfws_pkg::OCC_W-1:0]        res_occupancy,
    output logic                              res_is_empty,
    output logic                              res_is_full
);
    import cfws_pkg::*;

    localparam int IDX_W     = $clog2(DEPTH);
    localparam int CW        = (IDX_W + 1 > CAP_W) ? IDX_W + 1 : CAP_W;
    localparam int CAP_RESET = (DEFAULT_CAPACITY > DEPTH) ? DEPTH : DEFAULT_CAPACITY;

    function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] i,
                                                   input logic [CAP_W-1:0] cap);
        logic [CW-1:0] n;
        n = CW'(i) + CW'(1);
        return (n >= CW'(cap)) ? '0 : IDX_W'(n);
    endfunction

    // control state
    logic [CAP_W-1:0] cap_reg;
    logic [IDX_W-1:0] head_reg, tail_reg;
    logic [OCC_W-1:0] count_reg;

    // per-transaction payload
    op_t                  op_reg;
    logic [DATA_WIDTH-1:0] val_reg, front_reg, back_reg;
    logic [IDX_W-1:0]     scan_idx_reg;
    logic [OCC_W-1:0]     left_reg;
    res_code_t            status_reg;
    logic                 found_reg;
    logic [IDX_W-1:0]     slot_reg;

    // result register
    logic [ST_W-1:0]      r_status_reg;
    logic                 r_found_reg;
    logic [SLOT_W-1:0]    r_slot_reg;
    logic [VAL_W-1:0]     r_front_reg, r_back_reg;
    logic [OCC_W-1:0]     r_occ_reg;
    logic                 r_empty_reg, r_full_reg;

    logic [CAP_W-1:0]      cap_dec;
    logic [IDX_W-1:0]      head_inc, tail_inc, scan_inc, raddr;
    logic                  is_empty_now, is_full_now, push_ok;
    logic [DATA_WIDTH-1:0] rd_data;

    always_comb
    begin
        cap_dec = cfg_data;
        if (cfg_data == '0)
        begin
            cap_dec = CAP_W'(DEFAULT_CAPACITY);
        end
        if (int'(cap_dec) > DEPTH)
        begin
            cap_dec = CAP_W'(DEPTH);
        end
    end

    assign head_inc     = next_slot(head_reg, cap_reg);
    assign tail_inc     = next_slot(tail_reg, cap_reg);
    assign scan_inc     = next_slot(scan_idx_reg, cap_reg);
    assign is_empty_now = (count_reg == '0);
    assign is_full_now  = (count_reg >= OCC_W'(cap_reg));
    assign push_ok      = cmd.exec && (op_reg == OP_PUSH) && !is_full_now;

    always_comb
    begin
        case (op_reg)
            OP_POP:  raddr = head_inc;
            default: raddr = head_reg;
        endcase
        if (cmd.scan)
        begin
            raddr = scan_inc;
        end
    end

    cfws_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_slots (
        .clk   (clk),
        .we    (push_ok),
        .waddr (tail_inc),
        .wdata (val_reg),
        .raddr (raddr),
        .rdata (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg   <= CAP_W'(CAP_RESET);
            head_reg  <= '0;
            tail_reg  <= IDX_W'(CAP_RESET - 1);
            count_reg <= '0;
        end
        else if (cfg_we)
        begin
            cap_reg   <= cap_dec;
            head_reg  <= '0;
            tail_reg  <= IDX_W'(cap_dec - CAP_W'(1));
            count_reg <= '0;
        end
        else if (cmd.exec)
        begin
            if (push_ok)
            begin
                tail_reg  <= tail_inc;
                count_reg <= count_reg + OCC_W'(1);
            end
            else if ((op_reg == OP_POP) && !is_empty_now)
            begin
                head_reg  <= head_inc;
                count_reg <= count_reg - OCC_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg     <= op_t'(in_operation);
            val_reg    <= DATA_WIDTH'(in_value);
            status_reg <= ST_OK;
            found_reg  <= 1'b0;
            slot_reg   <= '0;
        end
        if (cmd.exec)
        begin
            case (op_reg)
                OP_PUSH:
                begin
                    if (is_full_now)
                    begin
                        status_reg <= ST_FULL;
                    end
                    else
                    begin
                        back_reg <= val_reg;
                        if (is_empty_now)
                        begin
                            front_reg <= val_reg;
                        end
                    end
                end
                OP_POP, OP_SEARCH:
                begin
                    if (is_empty_now)
                    begin
                        status_reg <= ST_EMPTY;
                    end
                end
                default:
                begin
                end
            endcase
            scan_idx_reg <= head_reg;
            left_reg     <= count_reg;
        end
        if (cmd.front_load)
        begin
            front_reg <= rd_data;
        end
        if (cmd.scan)
        begin
            if (stat.match)
            begin
                found_reg <= 1'b1;
                slot_reg  <= scan_idx_reg;
            end
            else
            begin
                scan_idx_reg <= scan_inc;
                left_reg     <= left_reg - OCC_W'(1);
            end
        end
        if (cmd.result_load)
        begin
            r_status_reg <= status_reg;
            r_found_reg  <= found_reg;
            r_slot_reg   <= SLOT_W'(slot_reg);
            r_front_reg  <= is_empty_now ? '0 : VAL_W'(front_reg);
            r_back_reg   <= is_empty_now ? '0 : VAL_W'(back_reg);
            r_occ_reg    <= count_reg;
            r_empty_reg  <= is_empty_now;
            r_full_reg   <= (count_reg == OCC_W'(cap_reg));
        end
    end

    assign stat.op    = op_reg;
    assign stat.empty = is_empty_now;
    assign stat.match = (rd_data == val_reg);
    assign stat.last  = (left_reg == OCC_W'(1));

    assign res_status      = r_status_reg;
    assign res_found       = r_found_reg;
    assign res_found_slot  = r_slot_reg;
    assign res_front_value = r_front_reg;
    assign res_back_value  = r_back_reg;
    assign res_occupancy   = r_occ_reg;
    assign res_is_empty    = r_empty_reg;
    assign res_is_full     = r_full_reg;

`ifndef SYNTHESIS
    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= OCC_W'(cap_reg))
        else $error("occupancy above capacity");
    a_cap_legal: assert property (@(posedge clk) disable iff (!rst_n)
        (cap_reg != '0) && (int'(cap_reg) <= DEPTH))
        else $error("capacity out of range");
    a_ptrs_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (CW'(head_reg) < CW'(cap_reg)) && (CW'(tail_reg) < CW'(cap_reg)))
        else $error("pointer beyond capacity");
`endif
endmodule
